@@ src/tega_pkg.sv @@
`default_nettype none

package tega_pkg;

    // Group length and the widths that follow from it
    localparam int GROUP_SIZE = 10;
    localparam int CNT_W      = $clog2(GROUP_SIZE + 1);

    // Field and register widths
    localparam int RAW_W      = 16;
    localparam int TERM_W     = RAW_W + 1;
    localparam int SUM_W      = 21;
    localparam int MEAN_W     = 17;
    localparam int MSD_W      = 7;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 17;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 24;
    localparam int M_USER_W   = 2;

    // Division by the group length as a multiplication by a rounded-up reciprocal.
    // The shift is wide enough that the quotient is exact for every sum magnitude.
    localparam int DIV_SHIFT = SUM_W + $clog2(GROUP_SIZE);
    localparam int MULT_W    = SUM_W + 1;
    localparam int PROD_W    = SUM_W + MULT_W;
    localparam int QUO_W     = PROD_W - DIV_SHIFT;
    localparam logic [MULT_W-1:0] DIV_MULT =
        MULT_W'(((longint'(1) << DIV_SHIFT) + GROUP_SIZE - 1) / GROUP_SIZE);

    // Saturation limits
    localparam logic signed [SUM_W-1:0]  SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]  SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [MEAN_W-1:0] MEAN_MAX = {1'b0, {(MEAN_W-1){1'b1}}};
    localparam logic signed [MEAN_W-1:0] MEAN_MIN = {1'b1, {(MEAN_W-1){1'b0}}};

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET_Y      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET_Z      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BAND_UPPER    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_BAND_LOWER    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_SIGN_DIFF = 3'd4;

    // Configuration reset values
    localparam logic signed [MEAN_W-1:0] BAND_UPPER_RST    = 17'sd134;
    localparam logic signed [MEAN_W-1:0] BAND_LOWER_RST    = -17'sd17;
    localparam logic [MSD_W-1:0]         MIN_SIGN_DIFF_RST = 7'd5;

    typedef struct packed {
        logic signed [RAW_W-1:0]  offset_y;
        logic signed [RAW_W-1:0]  offset_z;
        logic signed [MEAN_W-1:0] band_upper;
        logic signed [MEAN_W-1:0] band_lower;
        logic [MSD_W-1:0]         min_sign_diff;
    } cfg_t;

    // One accepted sample's signed contribution
    typedef struct packed {
        logic                     valid;
        logic                     neg;
        logic signed [TERM_W-1:0] term;
    } term_t;

    // A closed group
    typedef struct packed {
        logic                    valid;
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        neg_cnt;
        logic [CNT_W-1:0]        pos_cnt;
    } group_t;

    // One result
    typedef struct packed {
        logic                     valid;
        logic signed [MEAN_W-1:0] avg_error;
        logic                     in_band;
        logic                     oscillating;
    } result_t;

endpackage

`default_nettype wire

@@ src/tega_prep.sv @@
`default_nettype none

module tega_prep
    import tega_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                adv,
    input  wire logic                s_tvalid,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire cfg_t                cfg,
    output term_t                    term
);

    logic                     in_valid_reg;
    logic signed [RAW_W-1:0]  raw_y_reg;
    logic signed [RAW_W-1:0]  raw_z_reg;
    logic                     t_valid_reg;
    logic                     t_neg_reg;
    logic signed [TERM_W-1:0] t_term_reg;

    logic signed [TERM_W-1:0] y_corr;
    logic signed [TERM_W-1:0] z_corr;
    logic                     z_ok;
    logic                     y_neg;

    // Input register: one transfer per cycle while the pipeline advances.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            t_valid_reg  <= 1'b0;
        end else if (adv) begin
            in_valid_reg <= s_tvalid;
            t_valid_reg  <= in_valid_reg && z_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            raw_y_reg  <= s_tdata[RAW_W-1:0];
            raw_z_reg  <= s_tdata[2*RAW_W-1:RAW_W];
            t_neg_reg  <= y_neg;
            t_term_reg <= y_neg ? -z_corr : z_corr;
        end
    end

    // Offset correction; a negative corrected Z rejects the sample.
    always_comb begin
        y_corr = TERM_W'(raw_y_reg) - TERM_W'(cfg.offset_y);
        z_corr = TERM_W'(raw_z_reg) - TERM_W'(cfg.offset_z);
        z_ok   = !z_corr[TERM_W-1];
        y_neg  = y_corr[TERM_W-1];
    end

    assign term.valid = t_valid_reg;
    assign term.neg   = t_neg_reg;
    assign term.term  = t_term_reg;

endmodule

`default_nettype wire

@@ src/tega_accum.sv @@
`default_nettype none

module tega_accum
    import tega_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  adv,
    input  wire term_t term,
    output group_t     group
);

    logic [CNT_W-1:0]        acc_cnt_reg;
    logic [CNT_W-1:0]        neg_cnt_reg;
    logic [CNT_W-1:0]        pos_cnt_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                    g_valid_reg;
    logic signed [SUM_W-1:0] g_sum_reg;
    logic [CNT_W-1:0]        g_neg_reg;
    logic [CNT_W-1:0]        g_pos_reg;

    logic [CNT_W-1:0]        acc_cnt_next;
    logic [CNT_W-1:0]        neg_cnt_next;
    logic [CNT_W-1:0]        pos_cnt_next;
    logic signed [SUM_W:0]   sum_wide;
    logic signed [SUM_W-1:0] sum_next;
    logic                    close;

    // Count update and saturating sum.
    always_comb begin
        acc_cnt_next = acc_cnt_reg + CNT_W'(1);
        neg_cnt_next = neg_cnt_reg + CNT_W'(term.neg);
        pos_cnt_next = pos_cnt_reg + CNT_W'(!term.neg);
        close        = (acc_cnt_next == CNT_W'(GROUP_SIZE));
        sum_wide     = (SUM_W+1)'(sum_reg) + (SUM_W+1)'(term.term);
        if (sum_wide > (SUM_W+1)'(SUM_MAX)) begin
            sum_next = SUM_MAX;
        end else if (sum_wide < (SUM_W+1)'(SUM_MIN)) begin
            sum_next = SUM_MIN;
        end else begin
            sum_next = sum_wide[SUM_W-1:0];
        end
    end

    // Group state; it clears when the group closes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_cnt_reg <= '0;
            neg_cnt_reg <= '0;
            pos_cnt_reg <= '0;
            sum_reg     <= '0;
            g_valid_reg <= 1'b0;
        end else if (adv) begin
            g_valid_reg <= term.valid && close;
            if (term.valid) begin
                if (close) begin
                    acc_cnt_reg <= '0;
                    neg_cnt_reg <= '0;
                    pos_cnt_reg <= '0;
                    sum_reg     <= '0;
                end else begin
                    acc_cnt_reg <= acc_cnt_next;
                    neg_cnt_reg <= neg_cnt_next;
                    pos_cnt_reg <= pos_cnt_next;
                    sum_reg     <= sum_next;
                end
            end
        end
    end

    // Closed group handed on to the averaging stage.
    always_ff @(posedge aclk) begin
        if (adv) begin
            g_sum_reg <= sum_next;
            g_neg_reg <= neg_cnt_next;
            g_pos_reg <= pos_cnt_next;
        end
    end

    assign group.valid   = g_valid_reg;
    assign group.sum     = g_sum_reg;
    assign group.neg_cnt = g_neg_reg;
    assign group.pos_cnt = g_pos_reg;

endmodule

`default_nettype wire

@@ src/tega_close.sv @@
`default_nettype none

module tega_close
    import tega_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   adv,
    input  wire group_t group,
    input  wire cfg_t   cfg,
    output result_t     res
);

    logic                     p_valid_reg;
    logic                     p_neg_reg;
    logic                     p_osc_reg;
    logic [PROD_W-1:0]        p_prod_reg;
    logic                     still_moving_reg;
    logic                     r_valid_reg;
    logic signed [MEAN_W-1:0] r_mean_reg;
    logic                     r_inb_reg;
    logic                     r_osc_reg;

    logic [CNT_W-1:0]         diff;
    logic                     osc;
    logic signed [SUM_W-1:0]  sum_eff;
    logic [SUM_W-1:0]         mag;
    logic [PROD_W-1:0]        prod;
    logic [QUO_W-1:0]         quo;
    logic signed [QUO_W:0]    mean_wide;
    logic signed [MEAN_W-1:0] mean;
    logic                     inb;

    // Sign balance test, then the magnitude times the reciprocal.
    always_comb begin
        diff    = (group.neg_cnt >= group.pos_cnt) ? group.neg_cnt - group.pos_cnt
                                                   : group.pos_cnt - group.neg_cnt;
        osc     = MSD_W'(diff) < cfg.min_sign_diff;
        sum_eff = osc ? '0 : group.sum;
        mag     = sum_eff[SUM_W-1] ? SUM_W'(-sum_eff) : SUM_W'(sum_eff);
        prod    = PROD_W'(mag) * PROD_W'(DIV_MULT);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_neg_reg  <= sum_eff[SUM_W-1];
            p_osc_reg  <= osc;
            p_prod_reg <= prod;
        end
    end

    // Truncated mean, saturation and band test.
    always_comb begin
        quo       = p_prod_reg[PROD_W-1:DIV_SHIFT];
        mean_wide = p_neg_reg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        if (mean_wide > (QUO_W+1)'(MEAN_MAX)) begin
            mean = MEAN_MAX;
        end else if (mean_wide < (QUO_W+1)'(MEAN_MIN)) begin
            mean = MEAN_MIN;
        end else begin
            mean = mean_wide[MEAN_W-1:0];
        end
        inb = (mean < cfg.band_upper) && (mean > cfg.band_lower);
    end

    // A settled mean is passed once; repeated in-band groups report zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg      <= 1'b0;
            r_valid_reg      <= 1'b0;
            still_moving_reg <= 1'b1;
        end else if (adv) begin
            p_valid_reg <= group.valid;
            r_valid_reg <= p_valid_reg;
            if (p_valid_reg) begin
                still_moving_reg <= !inb;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r_mean_reg <= (inb && !still_moving_reg) ? '0 : mean;
            r_inb_reg  <= inb;
            r_osc_reg  <= p_osc_reg;
        end
    end

    assign res.valid       = r_valid_reg;
    assign res.avg_error   = r_mean_reg;
    assign res.in_band     = r_inb_reg;
    assign res.oscillating = r_osc_reg;

endmodule

`default_nettype wire

@@ src/tilt_error_group_averager.sv @@
// A group result moves through the input, term, group, product and result registers.
// Throughput: one sample per cycle; the five-register pipeline advances as a whole and holds
// only while a result waits in the output register with m_tready low.
// Reset: synchronous on aresetn low; the pipeline empties, the group counts and sum clear,
// the settled flag is cleared and the configuration registers return to their default values.
`default_nettype none

module tilt_error_group_averager
    import tega_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration writes
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // Sample stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,   // [15:0] raw_y, [31:16] raw_z
    // Result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_DATA_W-1:0]        m_tdata,   // [16:0] group mean error, [23:17] zero
    output logic [M_USER_W-1:0]        m_tuser    // [0] in_band, [1] oscillating
);

    cfg_t    cfg_reg;
    term_t   term;
    group_t  group;
    result_t res;
    logic    adv;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.offset_y      <= '0;
            cfg_reg.offset_z      <= '0;
            cfg_reg.band_upper    <= BAND_UPPER_RST;
            cfg_reg.band_lower    <= BAND_LOWER_RST;
            cfg_reg.min_sign_diff <= MIN_SIGN_DIFF_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_OFFSET_Y:      cfg_reg.offset_y      <= cfg_wdata[RAW_W-1:0];
                CFG_OFFSET_Z:      cfg_reg.offset_z      <= cfg_wdata[RAW_W-1:0];
                CFG_BAND_UPPER:    cfg_reg.band_upper    <= cfg_wdata[MEAN_W-1:0];
                CFG_BAND_LOWER:    cfg_reg.band_lower    <= cfg_wdata[MEAN_W-1:0];
                CFG_MIN_SIGN_DIFF: cfg_reg.min_sign_diff <= cfg_wdata[MSD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The pipeline moves unless a result is waiting to be taken.
    assign adv      = !res.valid || m_tready;
    assign s_tready = adv;

    tega_prep u_prep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .cfg      (cfg_reg),
        .term     (term)
    );

    tega_accum u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .term    (term),
        .group   (group)
    );

    tega_close u_close (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .group   (group),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // Result port.
    assign m_tvalid = res.valid;
    assign m_tdata  = M_DATA_W'($unsigned(res.avg_error));
    assign m_tuser  = {res.oscillating, res.in_band};

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import tega_pkg::*;

    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 220;
    localparam int DRAIN_CYCLES    = 10;
    localparam int QUIET_LIMIT     = 2000;
    localparam int MAX_REPORTS     = 60;

    typedef enum {IDLE_NONE, IDLE_SOME, IDLE_HEAVY} idle_mode_t;

    // Expected outcome of one closed group
    typedef struct packed {
        logic signed [MEAN_W-1:0] mean;
        logic                     in_band;
        logic                     oscillating;
    } group_mean_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [M_USER_W-1:0]   m_tuser;

    // Shadow copy of the configuration registers
    logic signed [RAW_W-1:0]  off_y       = '0;
    logic signed [RAW_W-1:0]  off_z       = '0;
    logic signed [MEAN_W-1:0] band_hi     = BAND_UPPER_RST;
    logic signed [MEAN_W-1:0] band_lo     = BAND_LOWER_RST;
    logic [MSD_W-1:0]         sign_margin = MIN_SIGN_DIFF_RST;

    // Shadow copy of the group state
    int     grp_len  = 0;
    int     grp_neg  = 0;
    int     grp_pos  = 0;
    longint grp_sum  = 0;
    bit     moving   = 1'b1;

    logic [S_DATA_W-1:0] sample_q[$];
    group_mean_t         pending_means[$];

    idle_mode_t idle_mode = IDLE_SOME;
    bit         s_fire = 1'b0;
    bit         m_fire = 1'b0;
    bit         holding = 1'b0;
    bit         gap_drawn = 1'b0;
    int         gap_left = 0;
    bit         stall_drawn = 1'b0;
    int         stall_left = 0;
    logic [S_DATA_W-1:0] cur_sample = '0;
    int         quiet_cycles = 0;

    int err_count        = 0;
    int samples_taken    = 0;
    int samples_rejected = 0;
    int groups_in_band   = 0;
    int groups_zeroed    = 0;
    int groups_osc       = 0;
    int results_seen     = 0;

    tilt_error_group_averager u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic longint sat(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int draw_wait();
        case (idle_mode)
            IDLE_NONE: return 0;
            IDLE_SOME: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 14)) : 0;
            default:   return $urandom_range(0, 14);
        endcase
    endfunction

    // Builds a raw sample from the wanted offset-corrected values, clipped to 16 bits.
    function automatic logic [S_DATA_W-1:0] pack_sample(input longint cy, input longint cz);
        longint ry;
        longint rz;
        ry = sat(cy + longint'(off_y), -32768, 32767);
        rz = sat(cz + longint'(off_z), -32768, 32767);
        return {rz[RAW_W-1:0], ry[RAW_W-1:0]};
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_REPORTS) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
        err_count++;
    endtask

    // Folds one accepted sample into the group and, when the group closes,
    // queues the mean, band and oscillation flags that the block must emit.
    function automatic void fold_sample(input logic [S_DATA_W-1:0] word);
        longint      cy;
        longint      cz;
        longint      diff;
        longint      mean_v;
        bit          osc;
        bit          inb;
        group_mean_t rec;
        cy = longint'($signed(word[RAW_W-1:0])) - longint'(off_y);
        cz = longint'($signed(word[S_DATA_W-1:RAW_W])) - longint'(off_z);
        samples_taken++;
        if (cz < 0) begin
            samples_rejected++;
            return;
        end
        if (cy < 0) begin
            cz = -cz;
            grp_neg++;
        end else begin
            grp_pos++;
        end
        grp_sum = sat(grp_sum + cz, -1048576, 1048575);
        grp_len++;
        if (grp_len < GROUP_SIZE) return;

        // Group closes: sign balance test, mean, then the settle band.
        diff = longint'(grp_neg) - longint'(grp_pos);
        if (diff < 0) diff = -diff;
        osc = diff < longint'(sign_margin);
        if (osc) grp_sum = 0;
        mean_v = sat(grp_sum / GROUP_SIZE, -65536, 65535);
        inb = (mean_v < longint'(band_hi)) && (mean_v > longint'(band_lo));
        rec.mean        = mean_v[MEAN_W-1:0];
        rec.in_band     = inb;
        rec.oscillating = osc;
        if (inb) begin
            if (!moving) begin
                rec.mean = '0;
                groups_zeroed++;
            end
            moving = 1'b0;
            groups_in_band++;
        end else begin
            moving = 1'b1;
        end
        if (osc) groups_osc++;
        pending_means.push_back(rec);
        grp_len = 0;
        grp_neg = 0;
        grp_pos = 0;
        grp_sum = 0;
    endfunction

    // Register write while the block is idle; the shadow copy follows at the write edge.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input longint val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
        @(posedge aclk);
        case (idx)
            CFG_OFFSET_Y:      off_y       = val[RAW_W-1:0];
            CFG_OFFSET_Z:      off_z       = val[RAW_W-1:0];
            CFG_BAND_UPPER:    band_hi     = val[MEAN_W-1:0];
            CFG_BAND_LOWER:    band_lo     = val[MEAN_W-1:0];
            CFG_MIN_SIGN_DIFF: sign_margin = val[MSD_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every sample is through and every group result has been seen.
    task automatic wait_drained();
        while (sample_q.size() != 0 || holding || pending_means.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Sample driver: presents queued samples with random gaps between transfers.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_fire) holding = 1'b0;
            if (!holding && sample_q.size() > 0) begin
                if (!gap_drawn) begin
                    gap_left  = draw_wait();
                    gap_drawn = 1'b1;
                end
                if (gap_left == 0) begin
                    cur_sample = sample_q.pop_front();
                    holding    = 1'b1;
                    gap_drawn  = 1'b0;
                end else begin
                    gap_left--;
                end
            end
        end
        s_tvalid <= holding;
        s_tdata  <= holding ? cur_sample : S_DATA_W'($urandom);
    end

    // Result receiver: holds tready low for a random stall while a result waits.
    always @(negedge aclk) begin
        if (m_fire || !stall_drawn) begin
            stall_left  = draw_wait();
            stall_drawn = 1'b1;
        end
        if (stall_left > 0) begin
            if (m_tvalid === 1'b1) stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: predicts on each sample transfer, checks each result transfer.
    always @(posedge aclk) begin
        group_mean_t rec;
        s_fire = (aresetn === 1'b1) && (s_tvalid === 1'b1) && (s_tready === 1'b1);
        m_fire = (aresetn === 1'b1) && (m_tvalid === 1'b1) && (m_tready === 1'b1);
        if (s_fire) fold_sample(s_tdata);
        if (m_fire) begin
            results_seen++;
            if (pending_means.size() == 0) begin
                report_mismatch($sformatf("result with no group pending (mean %0d)",
                                          $signed(m_tdata[MEAN_W-1:0])));
            end else begin
                rec = pending_means.pop_front();
                if (m_tdata[MEAN_W-1:0] !== rec.mean)
                    report_mismatch($sformatf("group mean %0d, expected %0d",
                                              $signed(m_tdata[MEAN_W-1:0]), rec.mean));
                if (m_tuser[0] !== rec.in_band)
                    report_mismatch($sformatf("in_band %b, expected %b",
                                              m_tuser[0], rec.in_band));
                if (m_tuser[1] !== rec.oscillating)
                    report_mismatch($sformatf("oscillating %b, expected %b",
                                              m_tuser[1], rec.oscillating));
            end
        end
        // Watchdog on cycles without any transfer
        if (s_fire || m_fire || aresetn !== 1'b1) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                         quiet_cycles, pending_means.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Stimulus: directed extremes first, then random phases under changing settings.
    initial begin
        longint nu_oy;
        longint nu_oz;
        longint nu_bu;
        longint nu_bl;
        longint nu_msd;
        longint centre;
        longint mag;
        longint cy;
        longint cz;
        int     n;
        int     pick;
        int     style;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Rejected samples under the reset settings: most negative and just negative Z.
        sample_q.push_back({16'h8000, 16'h8000});
        sample_q.push_back({16'hFFFF, 16'h7FFF});
        wait_drained();

        // With the most negative Z offset every sample is taken: full-scale means.
        write_reg(CFG_OFFSET_Z, -32768);
        repeat (GROUP_SIZE) sample_q.push_back({16'h7FFF, 16'h7FFF});
        repeat (GROUP_SIZE) sample_q.push_back({16'h7FFF, 16'h8000});

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            case (phase)
                0: begin
                    nu_oy = 0; nu_oz = 0; nu_bu = 134; nu_bl = -17; nu_msd = 5;
                end
                1: begin
                    nu_oy = -32768; nu_oz = 32767; nu_bu = 65535; nu_bl = -65536; nu_msd = 0;
                end
                2: begin
                    nu_oy = 32767; nu_oz = -32768; nu_bu = -65536; nu_bl = 65535;
                    nu_msd = 127;
                end
                default: begin
                    nu_oy  = longint'($urandom_range(0, 4000)) - 2000;
                    nu_oz  = longint'($urandom_range(0, 4000)) - 2000;
                    nu_bu  = longint'($urandom_range(0, 700)) - 150;
                    nu_bl  = nu_bu - longint'($urandom_range(0, 800)) + 50;
                    nu_msd = (phase == 3) ? GROUP_SIZE :
                             (phase == 4) ? 64 : longint'($urandom_range(0, 64));
                end
            endcase
            write_reg(CFG_OFFSET_Y, nu_oy);
            write_reg(CFG_OFFSET_Z, nu_oz);
            write_reg(CFG_BAND_UPPER, nu_bu);
            write_reg(CFG_BAND_LOWER, nu_bl);
            write_reg(CFG_MIN_SIGN_DIFF, nu_msd);
            idle_mode = idle_mode_t'(phase % 3);

            // Mostly whole groups of taken samples, with noise and rejects between them.
            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    sample_q.push_back(S_DATA_W'($urandom));
                    n++;
                end else if (pick == 1) begin
                    cy = longint'($urandom_range(0, 131070)) - 65535;
                    sample_q.push_back(pack_sample(cy, -longint'($urandom_range(1, 65535))));
                    n++;
                end else begin
                    style  = $urandom_range(0, 9);
                    centre = (longint'(band_hi) + longint'(band_lo)) / 2;
                    for (int k = 0; k < GROUP_SIZE; k++) begin
                        if (style < 5) begin
                            // Settling: one-sided samples aimed at the middle of the band
                            mag = (centre < 0) ? -centre : centre;
                            mag = mag + longint'($urandom_range(0, 20)) - 10;
                            if (mag < 0) mag = 0;
                            if (centre < 0)
                                cy = -longint'($urandom_range(1, 500));
                            else
                                cy = ($urandom_range(0, 2) == 0) ? 0 :
                                     longint'($urandom_range(1, 500));
                            cz = mag;
                        end else if (style < 8) begin
                            // Roughly balanced signs, so the oscillation test is close
                            cy = ($urandom_range(0, 1) == 1) ?
                                 -longint'($urandom_range(1, 300)) :
                                 longint'($urandom_range(0, 300));
                            cz = $urandom_range(0, 3000);
                        end else begin
                            cy = longint'($urandom_range(0, 131070)) - 65535;
                            cz = $urandom_range(0, 65535);
                        end
                        sample_q.push_back(pack_sample(cy, cz));
                    end
                    n += GROUP_SIZE;
                end
            end
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        $display("Run covered %0d samples (%0d rejected) under %0d register settings.",
                 samples_taken, samples_rejected, PHASES + 1);
        $display("Checked %0d group results: %0d in band, %0d repeated in band, %0d oscillating.",
                 results_seen, groups_in_band, groups_zeroed, groups_osc);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/tega_pkg.sv
src/tega_prep.sv
src/tega_accum.sv
src/tega_close.sv
src/tilt_error_group_averager.sv
tb/sv/tb_top.sv
